// ----- src/siph_pkg.sv -----
// ============================================================================
// siph_pkg
// Shared types, constants and round functions for the SipHash-2-4 stream block.
// ============================================================================
package siph_pkg;

    // Initialization constants XORed into the key at message start
    localparam logic [63:0] IV_A = 64'h736f6d6570736575;
    localparam logic [63:0] IV_B = 64'h646f72616e646f6d;
    localparam logic [63:0] IV_C = 64'h6c7967656e657261;
    localparam logic [63:0] IV_D = 64'h7465646279746573;

    // Finalization tweak on lane c
    localparam logic [63:0] FIN_TWEAK = 64'h0000_0000_0000_00FF;

    // Bytes in one message word, and the length step for a full word
    localparam int          WORD_BYTES = 8;
    localparam logic [7:0]  FULL_STEP  = 8'(WORD_BYTES);

    // APB register decode: register index sits in address bit 3 (8-byte stride)
    localparam int          APB_AW       = 4;
    localparam logic        REG_KEY_LOW  = 1'b0;
    localparam logic        REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // Message state handed from the absorb stage to the finalizer
    typedef struct packed {
        t_lanes      lanes;
        logic [63:0] last;   // length-tagged final block
    } t_handoff;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes mix_round(input t_lanes s);
        t_lanes v;
        v = s;
        v.a = v.a + v.b; v.b = rotl(v.b, 13); v.b = v.b ^ v.a; v.a = rotl(v.a, 32);
        v.c = v.c + v.d; v.d = rotl(v.d, 16); v.d = v.d ^ v.c;
        v.a = v.a + v.d; v.d = rotl(v.d, 21); v.d = v.d ^ v.a;
        v.c = v.c + v.b; v.b = rotl(v.b, 17); v.b = v.b ^ v.c; v.c = rotl(v.c, 32);
        return v;
    endfunction

    // One compression: two rounds around the message word
    function automatic t_lanes absorb(input t_lanes s, input logic [63:0] m);
        t_lanes v;
        v   = s;
        v.d = v.d ^ m;
        v   = mix_round(v);
        v   = mix_round(v);
        v.a = v.a ^ m;
        return v;
    endfunction

endpackage

// ----- src/siphash_2_4_stream.sv -----
// ============================================================================
// siphash_2_4_stream
// Keyed SipHash-2-4 over a word stream, one 64-bit hash per message.
// ============================================================================
//
// Channel   Dir  Fields (low bit up)                         Notes
// s_axis    in   tdata: message_word[63:0], byte_count[67:64] tlast = final_item
// m_axis    out  tdata: hash_value[63:0]                      one per message
// APB       in   0x0 key_low, 0x8 key_high (64-bit data)      pready tied high
//
// Throughput: one word per cycle while the finalizer takes final words. The lane
// register loop carries two unrolled rounds, which sets the clock period of the design.
// Latency: a final word passes the input register, stages s1, s2, s3 and the output register.
// Reset: synchronous, active low; keys clear to zero, pipeline empties and
// the next word starts a fresh message from the key.
// Stalls: a held hash stalls only the finalizer stages behind it; ordinary
// words keep flowing until a final word needs a free finalizer slot.
//
module siphash_2_4_stream (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // stream in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [71:0]                 s_axis_tdata,   // message_word[63:0], byte_count[67:64]
    input  logic                        s_axis_tlast,   // final_item
    // stream out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // hash_value[63:0]
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [siph_pkg::APB_AW-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    logic [63:0]        r_key_low;
    logic [63:0]        r_key_high;
    logic               cfg_wr;
    logic               reg_sel;

    logic               hand_valid;
    logic               hand_ready;
    siph_pkg::t_handoff hand;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == siph_pkg::REG_KEY_HIGH) ? r_key_high : r_key_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 64'd0;
        end else if (cfg_wr) begin
            case (reg_sel)
                siph_pkg::REG_KEY_LOW:  r_key_low  <= pwdata;
                siph_pkg::REG_KEY_HIGH: r_key_high <= pwdata;
                default:                r_key_low  <= r_key_low;
            endcase
        end
    end

    // ---------------- compression loop ----------------
    // Key is sampled when the first word of a message is absorbed.
    siph_absorb u_absorb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_low    (r_key_low),
        .i_key_high   (r_key_high),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_word       (s_axis_tdata[63:0]),
        .i_count      (s_axis_tdata[67:64]),
        .i_final      (s_axis_tlast),
        .o_hand_valid (hand_valid),
        .i_hand_ready (hand_ready),
        .o_hand       (hand)
    );

    // ---------------- finalization ----------------
    siph_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hand_valid (hand_valid),
        .o_hand_ready (hand_ready),
        .i_hand       (hand),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_hash       (m_axis_tdata)
    );

endmodule

// ----- src/siph_absorb.sv -----
// ============================================================================
// siph_absorb
// Input register and lane loop: two rounds per full word, builds the last block.
// ============================================================================
module siph_absorb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_key_low,
    input  logic [63:0]         i_key_high,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  logic [63:0]         i_word,
    input  logic [3:0]          i_count,
    input  logic                i_final,
    output logic                o_hand_valid,
    input  logic                i_hand_ready,
    output siph_pkg::t_handoff  o_hand
);

    logic               r_v;
    logic [63:0]        r_word;
    logic [3:0]         r_count;
    logic               r_final;
    logic               r_in_msg;
    siph_pkg::t_lanes   r_lanes;
    logic [7:0]         r_len;

    siph_pkg::t_lanes   start;
    siph_pkg::t_lanes   cur;
    siph_pkg::t_lanes   n_lanes;
    logic [7:0]         len_base;
    logic [7:0]         n_len;
    logic [7:0]         len_fin;
    logic [2:0]         tail;
    logic               full;
    logic [63:0]        mask;
    logic               consume;

    always_comb begin
        start.a = i_key_low  ^ siph_pkg::IV_A;
        start.b = i_key_high ^ siph_pkg::IV_B;
        start.c = i_key_low  ^ siph_pkg::IV_C;
        start.d = i_key_high ^ siph_pkg::IV_D;
    end

    assign cur      = r_in_msg ? r_lanes : start;
    assign len_base = r_in_msg ? r_len : 8'd0;

    // Non-final words always absorb in full; final ones only at count >= 8
    assign full    = !r_final || r_count[3];
    assign tail    = r_count[3] ? 3'd0 : r_count[2:0];
    assign n_lanes = siph_pkg::absorb(cur, r_word);
    assign n_len   = len_base + siph_pkg::FULL_STEP;
    assign len_fin = len_base + (r_count[3] ? siph_pkg::FULL_STEP : 8'd0) + {5'd0, tail};

    always_comb begin
        for (int i = 0; i < siph_pkg::WORD_BYTES; i++) begin
            mask[8*i +: 8] = (3'(i) < tail) ? 8'hFF : 8'h00;
        end
    end

    assign o_hand.lanes = full ? n_lanes : cur;
    assign o_hand.last  = {len_fin, 56'd0} | (r_word & mask);
    assign o_hand_valid = r_v && r_final;

    assign consume   = r_v && (!r_final || i_hand_ready);
    assign o_s_ready = !r_v || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_in_msg <= 1'b0;
        end else begin
            if (o_s_ready) begin
                r_v <= i_s_valid;
            end
            if (consume) begin
                r_in_msg <= !r_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_word  <= i_word;
            r_count <= i_count;
            r_final <= i_final;
        end
        if (consume && !r_final) begin
            r_lanes <= n_lanes;
            r_len   <= n_len;
        end
    end

endmodule

// ----- src/siph_final.sv -----
// ============================================================================
// siph_final
// Finalization pipeline: last block, tweak, four rounds, lane fold.
// ============================================================================
module siph_final (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_hand_valid,
    output logic                o_hand_ready,
    input  siph_pkg::t_handoff  i_hand,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [63:0]         o_hash
);

    logic               r_s1_v;
    siph_pkg::t_handoff r_s1;
    logic               r_s2_v;
    siph_pkg::t_lanes   r_s2_lanes;
    logic               r_s3_v;
    siph_pkg::t_lanes   r_s3_lanes;
    logic               r_out_v;
    logic [63:0]        r_hash;

    siph_pkg::t_lanes   n_s2_lanes;
    siph_pkg::t_lanes   tweaked;
    siph_pkg::t_lanes   n_s3_lanes;
    siph_pkg::t_lanes   fold;
    logic [63:0]        n_hash;
    logic               rdy_out;
    logic               rdy3;
    logic               rdy2;
    logic               rdy1;

    // Each stage moves when it is empty or its successor moves
    assign rdy_out      = !r_out_v || i_m_ready;
    assign rdy3         = !r_s3_v || rdy_out;
    assign rdy2         = !r_s2_v || rdy3;
    assign rdy1         = !r_s1_v || rdy2;
    assign o_hand_ready = rdy1;

    always_comb begin
        n_s2_lanes = siph_pkg::absorb(r_s1.lanes, r_s1.last);
        tweaked    = r_s2_lanes;
        tweaked.c  = r_s2_lanes.c ^ siph_pkg::FIN_TWEAK;
        n_s3_lanes = siph_pkg::mix_round(siph_pkg::mix_round(tweaked));
        fold       = siph_pkg::mix_round(siph_pkg::mix_round(r_s3_lanes));
        n_hash     = fold.a ^ fold.b ^ fold.c ^ fold.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy1)    r_s1_v  <= i_hand_valid;
            if (rdy2)    r_s2_v  <= r_s1_v;
            if (rdy3)    r_s3_v  <= r_s2_v;
            if (rdy_out) r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1)    r_s1       <= i_hand;
        if (rdy2)    r_s2_lanes <= n_s2_lanes;
        if (rdy3)    r_s3_lanes <= n_s3_lanes;
        if (rdy_out) r_hash     <= n_hash;
    end

    assign o_m_valid = r_out_v;
    assign o_hash    = r_hash;

endmodule

// ----- src/siph_checker.sv -----
// ============================================================================
// siph_checker
// Port-level checks for the SipHash-2-4 stream block, bound to the top level.
// ============================================================================
module siph_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [63:0]                 m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready
);

    // A stalled hash transaction keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("hash changed while stalled");

    // Pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // With the sink taking data, the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is free");

    // A write lands at the access phase, after the setup phase
    a_apb_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |-> $past(psel) && pready)
        else $error("configuration access without setup");

endmodule

bind siphash_2_4_stream siph_checker u_siph_checker (.*);
